[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define RRPE_ASSERT(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// antecedent in this cycle implies consequent in the next one
`define RRPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rrpe_pkg.sv]
// shared types and constants of the rssi ranging position engine
package rrpe_pkg;

    localparam logic [1:0] OP_CAL  = 2'd0;
    localparam logic [1:0] OP_GRID = 2'd1;
    localparam logic [1:0] OP_POS  = 2'd2;

    localparam logic [1:0] TAG_ORIGIN = 2'd0;
    localparam logic [1:0] TAG_Y      = 2'd1;
    localparam logic [1:0] TAG_X      = 2'd2;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;

    localparam logic CFG_CELL = 1'b0;
    localparam logic CFG_REFD = 1'b1;

    localparam int POW_W   = 11;
    localparam int F_W     = 62;
    localparam int ENTRY_W = 50;
    localparam int PP_W    = 49;
    localparam int ACC_W   = 74;
    localparam int PP_SHIFT = 25;

    localparam logic [8:0]  STEPS_PER_DECADE = 9'd432;
    localparam logic [31:0] Q28_ONE          = 32'd268435456;
    localparam logic [31:0] BASE_FACTOR_Q28  = 32'd269870052;
    localparam logic [63:0] Q28_HALF         = 64'd134217728;
    localparam logic [3:0]  LAST_FACTOR      = 4'd8;

    localparam logic [POW_W-1:0] REF_POWER_RESET = 11'd400;
    localparam logic [15:0]      CELL_RESET      = 16'd100;
    localparam logic [23:0]      REFD_RESET      = 24'd29850;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LOWER,
        CMD_DIFF,
        CMD_QSTEP,
        CMD_FINIT,
        CMD_FMUL,
        CMD_FSQ,
        CMD_DEC,
        CMD_ROUND,
        CMD_PMUL0,
        CMD_PMUL1,
        CMD_DSAT,
        CMD_GLOAD,
        CMD_AX_ERR,
        CMD_AX_C,
        CMD_AX_D0,
        CMD_AX_DF,
        CMD_AX_ABS,
        CMD_AX_DEN0,
        CMD_AX_DEN1,
        CMD_DIV_CHK,
        CMD_DIV_STEP,
        CMD_DIV_STORE,
        CMD_OUT
    } t_cmd;

    typedef enum logic [1:0] {
        DEST_GX,
        DEST_GY,
        DEST_XC,
        DEST_YC
    } t_dest;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOWER,
        S_DIFF,
        S_QSTEP,
        S_FINIT,
        S_FMUL,
        S_FSQ,
        S_DEC,
        S_ROUND,
        S_PMUL0,
        S_PMUL1,
        S_DSAT,
        S_GLOAD,
        S_AX_C,
        S_AX_D0,
        S_AX_DF,
        S_AX_ABS,
        S_AX_DEN0,
        S_AX_DEN1,
        S_DIV_CHK,
        S_DIV_STEP,
        S_DIV_STORE,
        S_FIN
    } t_state;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] sel;
    } t_ctrl_cmd;

    typedef struct packed {
        logic q_ge;
        logic q_zero;
        logic k_last;
        logic div_sat;
        logic bit_zero;
        logic cx_zero;
        logic cy_zero;
    } t_dp_status;

endpackage

[hw/rtl/rssi_ranging_position_engine.sv]
// top level of the rssi ranging position engine
//
// input stream: one word per command; tuser carries the op (calibrate, set grid,
// compute position), tdata the three averaged tag powers in 1/16 dB.
// output stream: one word per command; tuser echoes the op, tdata carries the
// stored grid cell counts, the position in cells and the zero corner flag.
// config channel: index 0 cell size in mm, index 1 reference distance in 1/256 mm;
// always ready, write only while no command is in flight.
// the engine handles one command at a time; s_tready is high only while idle.
// each distance first steps its table index down by 432 per decade, then runs
// a 9-step q28 loop of a multiply and a squaring per step; each quotient comes
// from the restoring divider, which skips its bit steps when it saturates.
// the finished result sits in an output register; the next command is taken
// while it waits, and a stalled receiver only holds the engine at its final
// step until the register frees up.
// reset (synchronous, active low) restores all reference powers to 25 dB,
// clears the corners and grid counts, and restores both config registers.
module rssi_ranging_position_engine #(
    parameter int DIST_TABLE_DEPTH = 2048,
    parameter int DIST_BITS        = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [10:0] power_origin, [21:11] power_y_corner, [32:22] power_x_corner
    input  logic [39:0] i_s_tdata,
    // [1:0] op
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] grid_x_cells, [31:16] grid_y_cells, [47:32] x_cell, [63:48] y_cell,
    // [64] zero_corner_error
    output logic [71:0] o_m_tdata,
    // [1:0] ack_code
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    rrpe_pkg::t_ctrl_cmd  cmd;
    rrpe_pkg::t_dp_status status;
    logic [15:0] gx, gy, xc, yc;
    logic        err;

    // config registers take a write on any cycle
    assign o_cfg_ready = 1'b1;

    rrpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_op        (i_s_tuser),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rrpe_datapath #(
        .DIST_TABLE_DEPTH (DIST_TABLE_DEPTH),
        .DIST_BITS        (DIST_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_s_tuser),
        .i_powers    (i_s_tdata[32:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ack       (o_m_tuser),
        .o_gx        (gx),
        .o_gy        (gy),
        .o_xc        (xc),
        .o_yc        (yc),
        .o_err       (err)
    );

    // pack result word, zero padded to whole bytes
    assign o_m_tdata = {7'd0, err, yc, xc, gy, gx};

endmodule

[hw/rtl/rrpe_datapath.sv]
// datapath: reference powers, distance evaluation, law of cosines and divider
module rrpe_datapath #(
    parameter int DIST_TABLE_DEPTH = 2048,
    parameter int DIST_BITS        = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrpe_pkg::t_ctrl_cmd   i_cmd,
    output rrpe_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_op,
    input  logic [32:0]           i_powers,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    output logic [1:0]            o_ack,
    output logic [15:0]           o_gx,
    output logic [15:0]           o_gy,
    output logic [15:0]           o_xc,
    output logic [15:0]           o_yc,
    output logic                  o_err
);

    localparam int IDX_W   = $clog2(DIST_TABLE_DEPTH);
    localparam int PROD_W  = 2 * DIST_BITS;
    localparam int W       = 2 * DIST_BITS + 18;
    localparam int PW      = rrpe_pkg::POW_W;
    localparam int ACC_W_L = rrpe_pkg::ACC_W;

    logic [15:0]    r_cell;
    logic [23:0]    r_refd;
    logic [PW-1:0]  r_refp [3];
    logic [PW-1:0]  r_pw [3];
    logic [1:0]     r_op;
    logic [DIST_BITS-1:0] r_cx, r_cy;
    logic [DIST_BITS-1:0] r_d [3];
    logic [15:0]    r_gx, r_gy, r_xc, r_yc;
    logic           r_err;
    logic [IDX_W-1:0] r_idx;
    logic [3:0]     r_q;
    logic [3:0]     r_k;
    logic [rrpe_pkg::F_W-1:0]     r_f;
    logic [31:0]    r_sq;
    logic [rrpe_pkg::ENTRY_W-1:0] r_entry;
    logic [rrpe_pkg::PP_W-1:0]    r_plo, r_phi;
    logic [PROD_W-1:0] r_prod;
    logic [W-1:0]   r_a, r_num, r_den, r_rem, r_dsh;
    logic [15:0]    r_quo;
    logic [3:0]     r_bit;
    logic [1:0]     r_o_ack;
    logic [15:0]    r_o_gx, r_o_gy, r_o_xc, r_o_yc;
    logic           r_o_err;

    logic [PW-1:0]  pw_sel, diff;
    logic [12:0]    diff_w;
    logic [63:0]    fmul_p, fsq_p;
    logic [ACC_W_L-1:0] acc_sum;
    logic [rrpe_pkg::ENTRY_W-1:0] dist_full;
    logic [DIST_BITS-1:0] dist_sat;
    logic [DIST_BITS-1:0] ax_c, ax_df;
    logic [W-1:0]   prod_w, den_top;
    logic           lower_all;

    always_comb begin
        pw_sel  = r_pw[i_cmd.sel];
        diff    = pw_sel - r_refp[i_cmd.sel];
        diff_w  = 13'(diff);
        fmul_p  = 64'(r_f[31:0]) * 64'(r_sq) + rrpe_pkg::Q28_HALF;
        fsq_p   = 64'(r_sq) * 64'(r_sq) + rrpe_pkg::Q28_HALF;
        acc_sum = ACC_W_L'(r_plo) + (ACC_W_L'(r_phi) << rrpe_pkg::PP_SHIFT);
        dist_full = acc_sum[ACC_W_L-1:24];
        if (dist_full > rrpe_pkg::ENTRY_W'({DIST_BITS{1'b1}})) begin
            dist_sat = {DIST_BITS{1'b1}};
        end else begin
            dist_sat = dist_full[DIST_BITS-1:0];
        end
        ax_c    = (i_cmd.sel == rrpe_pkg::SEL_Y) ? r_cy : r_cx;
        ax_df   = (i_cmd.sel == rrpe_pkg::SEL_Y) ? r_d[rrpe_pkg::TAG_Y] : r_d[rrpe_pkg::TAG_X];
        prod_w  = W'(r_prod);
        den_top = r_den << 16;
        lower_all = (r_op != rrpe_pkg::OP_GRID);
    end

    assign o_status.q_ge     = (r_idx >= IDX_W'(rrpe_pkg::STEPS_PER_DECADE));
    assign o_status.q_zero   = (r_q == 4'd0);
    assign o_status.k_last   = (r_k == rrpe_pkg::LAST_FACTOR);
    assign o_status.div_sat  = (r_num >= den_top);
    assign o_status.bit_zero = (r_bit == 4'd0);
    assign o_status.cx_zero  = (r_cx == '0);
    assign o_status.cy_zero  = (r_cy == '0);

    // state with defined reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= rrpe_pkg::CELL_RESET;
            r_refd <= rrpe_pkg::REFD_RESET;
            for (int t = 0; t < 3; t++) begin
                r_refp[t] <= rrpe_pkg::REF_POWER_RESET;
            end
            r_cx <= '0;
            r_cy <= '0;
            r_gx <= '0;
            r_gy <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rrpe_pkg::CFG_CELL) begin
                    r_cell <= i_cfg_data[15:0];
                end else begin
                    r_refd <= i_cfg_data;
                end
            end
            if (i_cmd.cmd == rrpe_pkg::CMD_LOWER) begin
                for (int t = 0; t < 3; t++) begin
                    if ((lower_all || t != 0) && r_pw[t] < r_refp[t]) begin
                        r_refp[t] <= r_pw[t];
                    end
                end
            end
            if (i_cmd.cmd == rrpe_pkg::CMD_DSAT && r_op == rrpe_pkg::OP_GRID) begin
                if (i_cmd.sel == rrpe_pkg::TAG_Y) begin
                    r_cy <= dist_sat;
                end else if (i_cmd.sel == rrpe_pkg::TAG_X) begin
                    r_cx <= dist_sat;
                end
            end
            if (i_cmd.cmd == rrpe_pkg::CMD_DIV_STORE) begin
                if (i_cmd.sel == rrpe_pkg::DEST_GX) begin
                    r_gx <= r_quo;
                end else if (i_cmd.sel == rrpe_pkg::DEST_GY) begin
                    r_gy <= r_quo;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cmd)
            rrpe_pkg::CMD_CAPTURE: begin
                r_op    <= i_op;
                r_pw[0] <= i_powers[10:0];
                r_pw[1] <= i_powers[21:11];
                r_pw[2] <= i_powers[32:22];
                r_xc    <= '0;
                r_yc    <= '0;
                r_err   <= 1'b0;
            end
            rrpe_pkg::CMD_DIFF: begin
                if (diff_w >= 13'(DIST_TABLE_DEPTH)) begin
                    r_idx <= IDX_W'(DIST_TABLE_DEPTH - 1);
                end else begin
                    r_idx <= diff_w[IDX_W-1:0];
                end
                r_q <= 4'd0;
            end
            rrpe_pkg::CMD_QSTEP: begin
                r_idx <= r_idx - IDX_W'(rrpe_pkg::STEPS_PER_DECADE);
                r_q   <= r_q + 4'd1;
            end
            rrpe_pkg::CMD_FINIT: begin
                r_f  <= rrpe_pkg::F_W'(rrpe_pkg::Q28_ONE);
                r_sq <= rrpe_pkg::BASE_FACTOR_Q28;
                r_k  <= 4'd0;
            end
            rrpe_pkg::CMD_FMUL: begin
                if (r_idx[r_k]) begin
                    r_f <= rrpe_pkg::F_W'(fmul_p[63:28]);
                end
            end
            rrpe_pkg::CMD_FSQ: begin
                r_sq <= fsq_p[59:28];
                r_k  <= r_k + 4'd1;
            end
            rrpe_pkg::CMD_DEC: begin
                r_f <= (r_f << 3) + (r_f << 1);
                r_q <= r_q - 4'd1;
            end
            rrpe_pkg::CMD_ROUND: begin
                r_entry <= rrpe_pkg::ENTRY_W'((r_f + rrpe_pkg::F_W'(2048)) >> 12);
            end
            rrpe_pkg::CMD_PMUL0: begin
                r_plo <= rrpe_pkg::PP_W'(r_entry[24:0]) * rrpe_pkg::PP_W'(r_refd);
            end
            rrpe_pkg::CMD_PMUL1: begin
                r_phi <= rrpe_pkg::PP_W'(r_entry[49:25]) * rrpe_pkg::PP_W'(r_refd);
            end
            rrpe_pkg::CMD_DSAT: begin
                r_d[i_cmd.sel] <= dist_sat;
            end
            rrpe_pkg::CMD_GLOAD: begin
                r_num <= W'((i_cmd.sel == rrpe_pkg::SEL_Y) ? r_cy : r_cx);
                r_den <= W'(r_cell);
            end
            rrpe_pkg::CMD_AX_ERR: begin
                r_err <= 1'b1;
            end
            rrpe_pkg::CMD_AX_C: begin
                r_prod <= PROD_W'(ax_c) * PROD_W'(ax_c);
            end
            rrpe_pkg::CMD_AX_D0: begin
                r_a    <= prod_w;
                r_prod <= PROD_W'(r_d[rrpe_pkg::TAG_ORIGIN]) * PROD_W'(r_d[rrpe_pkg::TAG_ORIGIN]);
            end
            rrpe_pkg::CMD_AX_DF: begin
                r_a    <= r_a + prod_w;
                r_prod <= PROD_W'(ax_df) * PROD_W'(ax_df);
            end
            rrpe_pkg::CMD_AX_ABS: begin
                r_num <= (r_a >= prod_w) ? (r_a - prod_w) : (prod_w - r_a);
            end
            rrpe_pkg::CMD_AX_DEN0: begin
                r_prod <= PROD_W'(ax_c) * PROD_W'(r_cell);
            end
            rrpe_pkg::CMD_AX_DEN1: begin
                r_den <= prod_w << 1;
            end
            rrpe_pkg::CMD_DIV_CHK: begin
                // quotient beyond 16 bits or zero divisor saturates
                r_quo <= o_status.div_sat ? 16'hFFFF : 16'd0;
                r_rem <= r_num;
                r_dsh <= r_den << 15;
                r_bit <= 4'd15;
            end
            rrpe_pkg::CMD_DIV_STEP: begin
                if (r_rem >= r_dsh) begin
                    r_rem        <= r_rem - r_dsh;
                    r_quo[r_bit] <= 1'b1;
                end
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 4'd1;
            end
            rrpe_pkg::CMD_DIV_STORE: begin
                if (i_cmd.sel == rrpe_pkg::DEST_XC) begin
                    r_xc <= r_quo;
                end else if (i_cmd.sel == rrpe_pkg::DEST_YC) begin
                    r_yc <= r_quo;
                end
            end
            rrpe_pkg::CMD_OUT: begin
                r_o_ack <= r_op;
                r_o_gx  <= r_gx;
                r_o_gy  <= r_gy;
                r_o_xc  <= r_xc;
                r_o_yc  <= r_yc;
                r_o_err <= r_err;
            end
            default: begin
            end
        endcase
    end

    assign o_ack = r_o_ack;
    assign o_gx  = r_o_gx;
    assign o_gy  = r_o_gy;
    assign o_xc  = r_o_xc;
    assign o_yc  = r_o_yc;
    assign o_err = r_o_err;

endmodule

[hw/rtl/rrpe_ctrl.sv]
// controller: sequences the datapath through each op and owns the handshakes
module rrpe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_op,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  rrpe_pkg::t_dp_status  i_status,
    output rrpe_pkg::t_ctrl_cmd   o_cmd
);

    rrpe_pkg::t_state r_state, n_state;
    rrpe_pkg::t_dest  r_dest, n_dest;
    logic [1:0]       r_op, n_op;
    logic [1:0]       r_tag, n_tag;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrpe_pkg::S_IDLE;
            r_dest   <= rrpe_pkg::DEST_GX;
            r_op     <= rrpe_pkg::OP_CAL;
            r_tag    <= rrpe_pkg::TAG_ORIGIN;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dest   <= n_dest;
            r_op     <= n_op;
            r_tag    <= n_tag;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dest     = r_dest;
        n_op       = r_op;
        n_tag      = r_tag;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_in_ready = 1'b0;
        o_cmd.cmd  = rrpe_pkg::CMD_NONE;
        o_cmd.sel  = r_tag;
        axis       = (r_dest == rrpe_pkg::DEST_YC) ? rrpe_pkg::SEL_Y : rrpe_pkg::SEL_X;
        unique case (r_state)
            rrpe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cmd = rrpe_pkg::CMD_CAPTURE;
                    n_op      = i_op;
                    n_state   = (i_op == rrpe_pkg::OP_CAL || i_op == rrpe_pkg::OP_GRID ||
                                 i_op == rrpe_pkg::OP_POS) ? rrpe_pkg::S_LOWER
                                                           : rrpe_pkg::S_FIN;
                end
            end
            rrpe_pkg::S_LOWER: begin
                o_cmd.cmd = rrpe_pkg::CMD_LOWER;
                n_tag     = (r_op == rrpe_pkg::OP_GRID) ? rrpe_pkg::TAG_Y
                                                        : rrpe_pkg::TAG_ORIGIN;
                n_state   = (r_op == rrpe_pkg::OP_CAL) ? rrpe_pkg::S_FIN : rrpe_pkg::S_DIFF;
            end
            rrpe_pkg::S_DIFF: begin
                o_cmd.cmd = rrpe_pkg::CMD_DIFF;
                n_state   = rrpe_pkg::S_QSTEP;
            end
            rrpe_pkg::S_QSTEP: begin
                if (i_status.q_ge) begin
                    o_cmd.cmd = rrpe_pkg::CMD_QSTEP;
                end else begin
                    n_state = rrpe_pkg::S_FINIT;
                end
            end
            rrpe_pkg::S_FINIT: begin
                o_cmd.cmd = rrpe_pkg::CMD_FINIT;
                n_state   = rrpe_pkg::S_FMUL;
            end
            rrpe_pkg::S_FMUL: begin
                o_cmd.cmd = rrpe_pkg::CMD_FMUL;
                n_state   = rrpe_pkg::S_FSQ;
            end
            rrpe_pkg::S_FSQ: begin
                o_cmd.cmd = rrpe_pkg::CMD_FSQ;
                n_state   = i_status.k_last ? rrpe_pkg::S_DEC : rrpe_pkg::S_FMUL;
            end
            rrpe_pkg::S_DEC: begin
                if (!i_status.q_zero) begin
                    o_cmd.cmd = rrpe_pkg::CMD_DEC;
                end else begin
                    n_state = rrpe_pkg::S_ROUND;
                end
            end
            rrpe_pkg::S_ROUND: begin
                o_cmd.cmd = rrpe_pkg::CMD_ROUND;
                n_state   = rrpe_pkg::S_PMUL0;
            end
            rrpe_pkg::S_PMUL0: begin
                o_cmd.cmd = rrpe_pkg::CMD_PMUL0;
                n_state   = rrpe_pkg::S_PMUL1;
            end
            rrpe_pkg::S_PMUL1: begin
                o_cmd.cmd = rrpe_pkg::CMD_PMUL1;
                n_state   = rrpe_pkg::S_DSAT;
            end
            rrpe_pkg::S_DSAT: begin
                o_cmd.cmd = rrpe_pkg::CMD_DSAT;
                if (r_tag != rrpe_pkg::TAG_X) begin
                    n_tag   = r_tag + 2'd1;
                    n_state = rrpe_pkg::S_DIFF;
                end else if (r_op == rrpe_pkg::OP_GRID) begin
                    n_dest  = rrpe_pkg::DEST_GY;
                    n_state = rrpe_pkg::S_GLOAD;
                end else begin
                    n_dest  = rrpe_pkg::DEST_XC;
                    n_state = rrpe_pkg::S_AX_C;
                end
            end
            rrpe_pkg::S_GLOAD: begin
                o_cmd.cmd = rrpe_pkg::CMD_GLOAD;
                o_cmd.sel = (r_dest == rrpe_pkg::DEST_GY) ? rrpe_pkg::SEL_Y : rrpe_pkg::SEL_X;
                n_state   = rrpe_pkg::S_DIV_CHK;
            end
            rrpe_pkg::S_AX_C: begin
                o_cmd.sel = axis;
                if ((axis == rrpe_pkg::SEL_Y) ? i_status.cy_zero : i_status.cx_zero) begin
                    // zero corner: flag it, the axis stays at zero
                    o_cmd.cmd = rrpe_pkg::CMD_AX_ERR;
                    if (r_dest == rrpe_pkg::DEST_XC) begin
                        n_dest = rrpe_pkg::DEST_YC;
                    end else begin
                        n_state = rrpe_pkg::S_FIN;
                    end
                end else begin
                    o_cmd.cmd = rrpe_pkg::CMD_AX_C;
                    n_state   = rrpe_pkg::S_AX_D0;
                end
            end
            rrpe_pkg::S_AX_D0: begin
                o_cmd.cmd = rrpe_pkg::CMD_AX_D0;
                o_cmd.sel = axis;
                n_state   = rrpe_pkg::S_AX_DF;
            end
            rrpe_pkg::S_AX_DF: begin
                o_cmd.cmd = rrpe_pkg::CMD_AX_DF;
                o_cmd.sel = axis;
                n_state   = rrpe_pkg::S_AX_ABS;
            end
            rrpe_pkg::S_AX_ABS: begin
                o_cmd.cmd = rrpe_pkg::CMD_AX_ABS;
                o_cmd.sel = axis;
                n_state   = rrpe_pkg::S_AX_DEN0;
            end
            rrpe_pkg::S_AX_DEN0: begin
                o_cmd.cmd = rrpe_pkg::CMD_AX_DEN0;
                o_cmd.sel = axis;
                n_state   = rrpe_pkg::S_AX_DEN1;
            end
            rrpe_pkg::S_AX_DEN1: begin
                o_cmd.cmd = rrpe_pkg::CMD_AX_DEN1;
                o_cmd.sel = axis;
                n_state   = rrpe_pkg::S_DIV_CHK;
            end
            rrpe_pkg::S_DIV_CHK: begin
                o_cmd.cmd = rrpe_pkg::CMD_DIV_CHK;
                n_state   = i_status.div_sat ? rrpe_pkg::S_DIV_STORE : rrpe_pkg::S_DIV_STEP;
            end
            rrpe_pkg::S_DIV_STEP: begin
                o_cmd.cmd = rrpe_pkg::CMD_DIV_STEP;
                if (i_status.bit_zero) begin
                    n_state = rrpe_pkg::S_DIV_STORE;
                end
            end
            rrpe_pkg::S_DIV_STORE: begin
                o_cmd.cmd = rrpe_pkg::CMD_DIV_STORE;
                o_cmd.sel = r_dest;
                unique case (r_dest)
                    rrpe_pkg::DEST_GY: begin
                        n_dest  = rrpe_pkg::DEST_GX;
                        n_state = rrpe_pkg::S_GLOAD;
                    end
                    rrpe_pkg::DEST_XC: begin
                        n_dest  = rrpe_pkg::DEST_YC;
                        n_state = rrpe_pkg::S_AX_C;
                    end
                    default: begin
                        n_state = rrpe_pkg::S_FIN;
                    end
                endcase
            end
            rrpe_pkg::S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.cmd = rrpe_pkg::CMD_OUT;
                    n_ovalid  = 1'b1;
                    n_state   = rrpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrpe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

[hw/rtl/rrpe_checker.sv]
// port-level checker for the rssi ranging position engine, with its bind
`include "assert_macros.svh"

module rrpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    localparam logic [1:0] ACK_POS = 2'd2;

    // a stalled result word stays offered
    `RRPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")

    // a stalled result word keeps its payload
    `RRPE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // one command at a time: ready drops right after an accept
    `RRPE_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "input taken while busy")

    // position fields and flag only come with a position result
    `RRPE_ASSERT(a_pos_only, i_clk, i_rst_n, !o_m_tvalid || o_m_tuser == ACK_POS || o_m_tdata[64:32] == 33'd0, "position fields set outside position op")

endmodule

bind rssi_ranging_position_engine rrpe_checker u_rrpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
